/* src/greedy_note_dispenser_macros.svh */
// Assertion macros for the greedy note dispenser.
`ifndef GREEDY_NOTE_DISPENSER_MACROS_SVH
`define GREEDY_NOTE_DISPENSER_MACROS_SVH

`ifndef SYNTH
// Same-cycle implication, checked on every rising clock edge out of reset.
`define GND_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication.
`define GND_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define GND_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define GND_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

/* src/gnd_pkg.sv */
// Types, codes and note constants shared by the note dispenser modules.
`timescale 1ns / 1ps

package gnd_pkg;

    typedef enum logic [1:0] {
        ST_PAID   = 2'd0,
        ST_LOW    = 2'd1,
        ST_NOCOMB = 2'd2,
        ST_LOADED = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_BAL,
        S_CHECK,
        S_MUL,
        S_FIX,
        S_TAKE,
        S_JUDGE,
        S_DONE
    } t_state;

    // Note kinds in greedy order, largest first.
    localparam logic [1:0] KIND_HUNDREDS = 2'd0;
    localparam logic [1:0] KIND_FIFTIES  = 2'd1;
    localparam logic [1:0] KIND_TWENTIES = 2'd2;
    localparam logic [1:0] KIND_TENS     = 2'd3;

    localparam int AMOUNT_BITS = 24;
    localparam int LOAD_BITS   = 16;
    localparam int VALUE_BITS  = 7;
    localparam int RECIP_BITS  = 32;

    typedef struct packed {
        logic       take_load;
        logic       take_wd;
        logic       bal_acc;
        logic       start;
        logic       mul;
        logic       fix;
        logic       take;
        logic       commit;
        logic       out_load;
        t_status    status;
        logic [1:0] kind;
    } t_dp_cmd;

    typedef struct packed {
        logic bal_low;
        logic rest_zero;
    } t_dp_sts;

    function automatic logic [VALUE_BITS-1:0] note_value(input logic [1:0] kind);
        logic [VALUE_BITS-1:0] v;
        unique case (kind)
            KIND_HUNDREDS: v = 7'd100;
            KIND_FIFTIES:  v = 7'd50;
            KIND_TWENTIES: v = 7'd20;
            default:       v = 7'd10;
        endcase
        return v;
    endfunction

    // floor(2^32 / value): quotient estimate is exact or one short.
    function automatic logic [RECIP_BITS-1:0] note_recip(input logic [1:0] kind);
        logic [RECIP_BITS-1:0] m;
        unique case (kind)
            KIND_HUNDREDS: m = 32'd42949672;
            KIND_FIFTIES:  m = 32'd85899345;
            KIND_TWENTIES: m = 32'd214748364;
            default:       m = 32'd429496729;
        endcase
        return m;
    endfunction

endpackage

/* src/gnd_ctrl.sv */
// Controller state machine: sequences load, balance check and greedy steps.
`timescale 1ns / 1ps

module gnd_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_cmd_withdraw,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    input  gnd_pkg::t_dp_sts  i_sts,
    output gnd_pkg::t_dp_cmd  o_cmd
);

    gnd_pkg::t_state  r_state, n_state;
    logic [1:0]       r_kind, n_kind;
    gnd_pkg::t_status r_status, n_status;
    logic             r_out_valid, n_out_valid;
    logic             w_out_free;

    assign w_out_free  = !r_out_valid || i_out_ready;
    assign o_out_valid = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= gnd_pkg::S_IDLE;
            r_kind      <= gnd_pkg::KIND_HUNDREDS;
            r_status    <= gnd_pkg::ST_PAID;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_kind      <= n_kind;
            r_status    <= n_status;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_kind     = r_kind;
        n_status   = r_status;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        o_cmd.kind   = r_kind;
        o_cmd.status = r_status;

        unique case (r_state)
            gnd_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    n_kind = gnd_pkg::KIND_HUNDREDS;
                    if (i_cmd_withdraw) begin
                        o_cmd.take_wd = 1'b1;
                        n_state       = gnd_pkg::S_CHECK;
                    end else begin
                        o_cmd.take_load = 1'b1;
                        n_state         = gnd_pkg::S_BAL;
                    end
                end
            end
            gnd_pkg::S_BAL: begin
                o_cmd.bal_acc = 1'b1;
                if (r_kind == gnd_pkg::KIND_TENS) begin
                    n_status = gnd_pkg::ST_LOADED;
                    n_state  = gnd_pkg::S_DONE;
                end else begin
                    n_kind = r_kind + 2'd1;
                end
            end
            gnd_pkg::S_CHECK: begin
                if (i_sts.bal_low) begin
                    n_status = gnd_pkg::ST_LOW;
                    n_state  = gnd_pkg::S_DONE;
                end else begin
                    o_cmd.start = 1'b1;
                    n_kind      = gnd_pkg::KIND_HUNDREDS;
                    n_state     = gnd_pkg::S_MUL;
                end
            end
            gnd_pkg::S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = gnd_pkg::S_FIX;
            end
            gnd_pkg::S_FIX: begin
                o_cmd.fix = 1'b1;
                n_state   = gnd_pkg::S_TAKE;
            end
            gnd_pkg::S_TAKE: begin
                o_cmd.take = 1'b1;
                if (r_kind == gnd_pkg::KIND_TENS) begin
                    n_state = gnd_pkg::S_JUDGE;
                end else begin
                    n_kind  = r_kind + 2'd1;
                    n_state = gnd_pkg::S_MUL;
                end
            end
            gnd_pkg::S_JUDGE: begin
                // Commit only when the greedy pass used up the whole amount.
                if (i_sts.rest_zero) begin
                    o_cmd.commit = 1'b1;
                    n_status     = gnd_pkg::ST_PAID;
                end else begin
                    n_status = gnd_pkg::ST_NOCOMB;
                end
                n_state = gnd_pkg::S_DONE;
            end
            gnd_pkg::S_DONE: begin
                if (w_out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = gnd_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = gnd_pkg::S_IDLE;
            end
        endcase
    end

    always_comb begin
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

endmodule

/* src/gnd_dpath.sv */
// Datapath: note stock, balance, reciprocal divider step and result register.
`timescale 1ns / 1ps

module gnd_dpath #(
    parameter int COUNT_BITS = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  gnd_pkg::t_dp_cmd                       i_cmd,
    output gnd_pkg::t_dp_sts                       o_sts,
    input  logic [gnd_pkg::AMOUNT_BITS-1:0]        i_amount,
    input  logic [gnd_pkg::LOAD_BITS-1:0]          i_load_tens,
    input  logic [gnd_pkg::LOAD_BITS-1:0]          i_load_twenties,
    input  logic [gnd_pkg::LOAD_BITS-1:0]          i_load_fifties,
    input  logic [gnd_pkg::LOAD_BITS-1:0]          i_load_hundreds,
    output gnd_pkg::t_status                       o_status,
    output logic [gnd_pkg::LOAD_BITS-1:0]          o_paid [4],
    output logic [gnd_pkg::LOAD_BITS-1:0]          o_left [4],
    output logic [gnd_pkg::AMOUNT_BITS-1:0]        o_balance
);

    localparam int AB       = gnd_pkg::AMOUNT_BITS;
    localparam int LB       = gnd_pkg::LOAD_BITS;
    localparam int VB       = gnd_pkg::VALUE_BITS;
    localparam int RB       = gnd_pkg::RECIP_BITS;
    localparam int BAL_BITS = COUNT_BITS + 8;
    localparam int CMP_BITS = (COUNT_BITS > AB) ? COUNT_BITS : AB;
    localparam int PROD_BITS = AB + RB;

    logic [COUNT_BITS-1:0] r_stock [4];
    logic [COUNT_BITS-1:0] r_paid  [4];
    logic [BAL_BITS-1:0]   r_bal;
    logic [AB-1:0]         r_amt;
    logic [AB-1:0]         r_rest;
    logic [PROD_BITS-1:0]  r_prod;
    logic [AB-1:0]         r_want;

    gnd_pkg::t_status      r_out_status;
    logic [LB-1:0]         r_out_paid [4];
    logic [LB-1:0]         r_out_left [4];
    logic [AB-1:0]         r_out_bal;

    logic [VB-1:0]         w_val;
    logic [RB-1:0]         w_recip;
    logic [COUNT_BITS-1:0] w_load [4];
    logic [AB-1:0]         w_q0;
    logic [AB+VB-1:0]      w_q0_val;
    logic [AB-1:0]         w_r0;
    logic [CMP_BITS-1:0]   w_want_c;
    logic [CMP_BITS-1:0]   w_stock_c;
    logic [CMP_BITS-1:0]   w_take_c;
    logic [CMP_BITS+VB-1:0] w_take_val;
    logic [BAL_BITS-1:0]   w_bal_add;

    assign w_val   = gnd_pkg::note_value(i_cmd.kind);
    assign w_recip = gnd_pkg::note_recip(i_cmd.kind);

    // Fit the 16-bit load counts to the stock width.
    always_comb begin
        logic [COUNT_BITS+LB-1:0] ext [4];
        ext[gnd_pkg::KIND_HUNDREDS] = (COUNT_BITS+LB)'(i_load_hundreds);
        ext[gnd_pkg::KIND_FIFTIES]  = (COUNT_BITS+LB)'(i_load_fifties);
        ext[gnd_pkg::KIND_TWENTIES] = (COUNT_BITS+LB)'(i_load_twenties);
        ext[gnd_pkg::KIND_TENS]     = (COUNT_BITS+LB)'(i_load_tens);
        for (int k = 0; k < 4; k++) begin
            w_load[k] = ext[k][COUNT_BITS-1:0];
        end
    end

    assign w_bal_add = BAL_BITS'(r_stock[i_cmd.kind]) * BAL_BITS'(w_val);

    // Estimate is exact or one short; one compare fixes it.
    assign w_q0     = r_prod[PROD_BITS-1:RB];
    assign w_q0_val = (AB+VB)'(w_q0) * (AB+VB)'(w_val);
    assign w_r0     = r_rest - w_q0_val[AB-1:0];

    assign w_want_c   = CMP_BITS'(r_want);
    assign w_stock_c  = CMP_BITS'(r_stock[i_cmd.kind]);
    assign w_take_c   = (w_want_c < w_stock_c) ? w_want_c : w_stock_c;
    assign w_take_val = (CMP_BITS+VB)'(w_take_c) * (CMP_BITS+VB)'(w_val);

    assign o_sts.bal_low   = (BAL_BITS+AB)'(r_bal) < (BAL_BITS+AB)'(r_amt);
    assign o_sts.rest_zero = (r_rest == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 4; k++) begin
                r_stock[k] <= '0;
            end
            r_bal <= '0;
        end else begin
            if (i_cmd.take_load) begin
                for (int k = 0; k < 4; k++) begin
                    r_stock[k] <= w_load[k];
                end
                r_bal <= '0;
            end
            if (i_cmd.bal_acc) begin
                r_bal <= r_bal + w_bal_add;
            end
            if (i_cmd.commit) begin
                for (int k = 0; k < 4; k++) begin
                    r_stock[k] <= r_stock[k] - r_paid[k];
                end
                // The notes paid add up to the amount exactly.
                r_bal <= r_bal - BAL_BITS'(r_amt);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take_wd) begin
            r_amt <= i_amount;
        end
        if (i_cmd.start) begin
            r_rest <= r_amt;
        end
        if (i_cmd.mul) begin
            r_prod <= PROD_BITS'(r_rest) * PROD_BITS'(w_recip);
        end
        if (i_cmd.fix) begin
            r_want <= (w_r0 >= AB'(w_val)) ? w_q0 + AB'(1) : w_q0;
        end
        if (i_cmd.take) begin
            r_paid[i_cmd.kind] <= w_take_c[COUNT_BITS-1:0];
            r_rest             <= r_rest - w_take_val[AB-1:0];
        end
    end

    // Result register: paid counts show only for a completed withdrawal.
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            logic [COUNT_BITS+LB-1:0] pext;
            logic [COUNT_BITS+LB-1:0] lext;
            logic [BAL_BITS+AB-1:0]   bext;
            r_out_status <= i_cmd.status;
            for (int k = 0; k < 4; k++) begin
                pext = (COUNT_BITS+LB)'(r_paid[k]);
                lext = (COUNT_BITS+LB)'(r_stock[k]);
                r_out_paid[k] <= (i_cmd.status == gnd_pkg::ST_PAID) ? pext[LB-1:0] : '0;
                r_out_left[k] <= lext[LB-1:0];
            end
            bext = (BAL_BITS+AB)'(r_bal);
            r_out_bal <= bext[AB-1:0];
        end
    end

    assign o_status  = r_out_status;
    assign o_paid    = r_out_paid;
    assign o_left    = r_out_left;
    assign o_balance = r_out_bal;

endmodule

/* src/greedy_note_dispenser.sv */
// A withdrawal that passes the balance check walks the four note kinds through one
// shared reciprocal divide step each (multiply, fix, take); a load sums the balance
// one note kind a cycle. One item is in work at a time, and a stalled result holds
// the next item off.
// Reset (synchronous, active low) clears the stock, the balance and all handshakes.
`timescale 1ns / 1ps
`include "greedy_note_dispenser_macros.svh"

module greedy_note_dispenser #(
    parameter int COUNT_BITS = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_s_axis_tvalid,
    output logic          o_s_axis_tready,
    // amount[23:0], load_tens[39:24], load_twenties[55:40],
    // load_fifties[71:56], load_hundreds[87:72]
    input  logic [87:0]   i_s_axis_tdata,
    // cmd[0]
    input  logic [0:0]    i_s_axis_tuser,
    output logic          o_m_axis_tvalid,
    input  logic          i_m_axis_tready,
    // paid_tens[15:0], paid_twenties[31:16], paid_fifties[47:32],
    // paid_hundreds[63:48], left_tens[79:64], left_twenties[95:80],
    // left_fifties[111:96], left_hundreds[127:112], balance[151:128]
    output logic [151:0]  o_m_axis_tdata,
    // status[1:0]
    output logic [1:0]    o_m_axis_tuser
);

    gnd_pkg::t_dp_cmd w_cmd;
    gnd_pkg::t_dp_sts w_sts;
    gnd_pkg::t_status w_status;
    logic [15:0]      w_paid [4];
    logic [15:0]      w_left [4];
    logic [23:0]      w_balance;

    gnd_ctrl u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_s_axis_tvalid),
        .i_cmd_withdraw (i_s_axis_tuser[0]),
        .o_in_ready     (o_s_axis_tready),
        .o_out_valid    (o_m_axis_tvalid),
        .i_out_ready    (i_m_axis_tready),
        .i_sts          (w_sts),
        .o_cmd          (w_cmd)
    );

    gnd_dpath #(
        .COUNT_BITS (COUNT_BITS)
    ) u_dpath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .o_sts           (w_sts),
        .i_amount        (i_s_axis_tdata[23:0]),
        .i_load_tens     (i_s_axis_tdata[39:24]),
        .i_load_twenties (i_s_axis_tdata[55:40]),
        .i_load_fifties  (i_s_axis_tdata[71:56]),
        .i_load_hundreds (i_s_axis_tdata[87:72]),
        .o_status        (w_status),
        .o_paid          (w_paid),
        .o_left          (w_left),
        .o_balance       (w_balance)
    );

    assign o_m_axis_tuser = w_status;
    assign o_m_axis_tdata = {
        w_balance,
        w_left[gnd_pkg::KIND_HUNDREDS],
        w_left[gnd_pkg::KIND_FIFTIES],
        w_left[gnd_pkg::KIND_TWENTIES],
        w_left[gnd_pkg::KIND_TENS],
        w_paid[gnd_pkg::KIND_HUNDREDS],
        w_paid[gnd_pkg::KIND_FIFTIES],
        w_paid[gnd_pkg::KIND_TWENTIES],
        w_paid[gnd_pkg::KIND_TENS]
    };

    // Only a completed withdrawal shows notes paid.
    `GND_ASSERT_IMPLY(a_paid_zero_unless_paid, i_clk, i_rst_n, o_m_axis_tvalid && (o_m_axis_tuser != gnd_pkg::ST_PAID), o_m_axis_tdata[63:0] == 64'd0)
    // A result appears only after the input side has been closed for the work.
    `GND_ASSERT_IMPLY(a_result_after_busy, i_clk, i_rst_n, $rose(o_m_axis_tvalid), !$past(o_s_axis_tready))
    // An accepted item keeps the input side closed in the next cycle.
    `GND_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_s_axis_tvalid && o_s_axis_tready, !o_s_axis_tready)

endmodule

/* bench/tb_greedy_note_dispenser.sv */
// Self-checking testbench for the greedy note dispenser: directed rows, then random traffic.
`timescale 1ns / 1ps

module tb_greedy_note_dispenser;

    localparam int       RESET_CYCLES  = 10;
    localparam int       RANDOM_ITEMS  = 1100;
    localparam int       DRAIN_CYCLES  = 40;
    localparam int       STALL_LIMIT   = 2000;
    localparam int       REPORT_LIMIT  = 10;
    localparam logic     CMD_LOAD      = 1'b0;
    localparam logic     CMD_WITHDRAW  = 1'b1;
    // Note worth indexed by note kind, largest first.
    localparam logic [3:0][6:0] NOTE_WORTH = {7'd10, 7'd20, 7'd50, 7'd100};

    typedef struct packed {
        logic        cmd;
        logic [15:0] load_hundreds;
        logic [15:0] load_fifties;
        logic [15:0] load_twenties;
        logic [15:0] load_tens;
        logic [23:0] amount;
    } t_request;

    typedef struct packed {
        gnd_pkg::t_status status;
        logic [15:0]      paid_tens;
        logic [15:0]      paid_twenties;
        logic [15:0]      paid_fifties;
        logic [15:0]      paid_hundreds;
        logic [15:0]      left_tens;
        logic [15:0]      left_twenties;
        logic [15:0]      left_fifties;
        logic [15:0]      left_hundreds;
        logic [23:0]      balance;
    } t_receipt;

    typedef struct packed {
        t_request req;
        logic     golden;
        t_receipt slip;
    } t_vector;

    logic          i_clk   = 1'b0;
    logic          i_rst_n = 1'b0;
    logic          s_valid = 1'b0;
    logic [87:0]   s_data  = '0;
    logic [0:0]    s_user  = '0;
    logic          m_ready = 1'b0;
    logic          o_s_axis_tready;
    logic          o_m_axis_tvalid;
    logic [151:0]  o_m_axis_tdata;
    logic [1:0]    o_m_axis_tuser;

    logic [3:0][15:0] vault = '0;
    t_receipt         pending_receipts [$];
    t_vector          directed_rows [$];
    logic             idle_on = 1'b1;
    int               mismatches = 0;
    int               receipts_seen = 0;
    int               items_sent = 0;
    int               idle_cycles = 0;
    int               recv_wait = 0;
    int               tally [4] = '{0, 0, 0, 0};

    always #6 i_clk = ~i_clk;

    greedy_note_dispenser #(
        .COUNT_BITS(16)
    ) i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_s_axis_tvalid(s_valid),
        .o_s_axis_tready(o_s_axis_tready),
        .i_s_axis_tdata (s_data),
        .i_s_axis_tuser (s_user),
        .o_m_axis_tvalid(o_m_axis_tvalid),
        .i_m_axis_tready(m_ready),
        .o_m_axis_tdata (o_m_axis_tdata),
        .o_m_axis_tuser (o_m_axis_tuser)
    );

    function automatic logic [63:0] vault_total();
        logic [63:0] sum;
        int          k;
        sum = '0;
        for (k = 0; k < 4; k++) sum += 64'(vault[k]) * 64'(NOTE_WORTH[k]);
        return sum;
    endfunction

    // Apply one item to the stock and return the receipt it should produce.
    function automatic t_receipt dispense(input t_request rq);
        t_receipt         r;
        gnd_pkg::t_status st;
        logic [3:0][15:0] give;
        logic [63:0]      rest;
        logic [63:0]      want;
        int               k;
        give = '0;
        if (rq.cmd == CMD_LOAD) begin
            vault[gnd_pkg::KIND_TENS]     = rq.load_tens;
            vault[gnd_pkg::KIND_TWENTIES] = rq.load_twenties;
            vault[gnd_pkg::KIND_FIFTIES]  = rq.load_fifties;
            vault[gnd_pkg::KIND_HUNDREDS] = rq.load_hundreds;
            st = gnd_pkg::ST_LOADED;
        end else if (vault_total() < 64'(rq.amount)) begin
            st = gnd_pkg::ST_LOW;
        end else begin
            rest = 64'(rq.amount);
            for (k = 0; k < 4; k++) begin
                want    = rest / 64'(NOTE_WORTH[k]);
                give[k] = (want < 64'(vault[k])) ? want[15:0] : vault[k];
                rest    = rest - 64'(give[k]) * 64'(NOTE_WORTH[k]);
            end
            if (rest != 0) begin
                st   = gnd_pkg::ST_NOCOMB;
                give = '0;
            end else begin
                st = gnd_pkg::ST_PAID;
                for (k = 0; k < 4; k++) vault[k] = vault[k] - give[k];
            end
        end
        r.status        = st;
        r.paid_tens     = give[gnd_pkg::KIND_TENS];
        r.paid_twenties = give[gnd_pkg::KIND_TWENTIES];
        r.paid_fifties  = give[gnd_pkg::KIND_FIFTIES];
        r.paid_hundreds = give[gnd_pkg::KIND_HUNDREDS];
        r.left_tens     = vault[gnd_pkg::KIND_TENS];
        r.left_twenties = vault[gnd_pkg::KIND_TWENTIES];
        r.left_fifties  = vault[gnd_pkg::KIND_FIFTIES];
        r.left_hundreds = vault[gnd_pkg::KIND_HUNDREDS];
        r.balance       = 24'(vault_total());
        return r;
    endfunction

    function automatic int pause_len();
        return idle_on ? int'($urandom_range(0, 6)) : 0;
    endfunction

    function automatic t_request withdraw(input logic [23:0] amount);
        t_request rq;
        rq        = '0;
        rq.cmd    = CMD_WITHDRAW;
        rq.amount = amount;
        return rq;
    endfunction

    function automatic t_request stock_load(input logic [15:0] tens, twenties, fifties,
                                            hundreds, input logic [23:0] junk);
        t_request rq;
        rq.cmd           = CMD_LOAD;
        rq.load_tens     = tens;
        rq.load_twenties = twenties;
        rq.load_fifties  = fifties;
        rq.load_hundreds = hundreds;
        rq.amount        = junk;
        return rq;
    endfunction

    // paid and left are packed tens in the low bits, hundreds in the high bits.
    function automatic t_receipt slip(input gnd_pkg::t_status st, input logic [63:0] paid,
                                      input logic [63:0] left, input logic [23:0] bal);
        t_receipt r;
        r.status        = st;
        r.paid_tens     = paid[15:0];
        r.paid_twenties = paid[31:16];
        r.paid_fifties  = paid[47:32];
        r.paid_hundreds = paid[63:48];
        r.left_tens     = left[15:0];
        r.left_twenties = left[31:16];
        r.left_fifties  = left[47:32];
        r.left_hundreds = left[63:48];
        r.balance       = bal;
        return r;
    endfunction

    task automatic add_row(input t_request rq, input logic golden, input t_receipt s);
        t_vector v;
        v.req    = rq;
        v.golden = golden;
        v.slip   = s;
        directed_rows.push_back(v);
    endtask

    // Mostly sensible withdrawals against the current stock, with some loads and noise.
    function automatic t_request random_request();
        t_request    rq;
        logic [63:0] funds;
        int          pick;
        int          top;
        funds            = vault_total();
        rq.cmd           = CMD_WITHDRAW;
        rq.amount        = 24'($urandom);
        rq.load_tens     = 16'($urandom);
        rq.load_twenties = 16'($urandom);
        rq.load_fifties  = 16'($urandom);
        rq.load_hundreds = 16'($urandom);
        pick             = $urandom_range(0, 99);
        if (pick < 12) begin
            rq.cmd = CMD_LOAD;
            case ($urandom_range(0, 3))
                0: begin
                    rq.load_tens     = 16'($urandom_range(0, 15));
                    rq.load_twenties = 16'($urandom_range(0, 15));
                    rq.load_fifties  = 16'($urandom_range(0, 15));
                    rq.load_hundreds = 16'($urandom_range(0, 15));
                end
                1: begin
                    rq.load_tens     = $urandom_range(0, 1) ? 16'($urandom_range(0, 300)) : '0;
                    rq.load_twenties = $urandom_range(0, 1) ? 16'($urandom_range(0, 300)) : '0;
                    rq.load_fifties  = $urandom_range(0, 1) ? 16'($urandom_range(0, 300)) : '0;
                    rq.load_hundreds = $urandom_range(0, 1) ? 16'($urandom_range(0, 300)) : '0;
                end
                2: ; // keep full-range counts
                default: begin
                    rq.load_tens     = '0;
                    rq.load_twenties = 16'($urandom_range(0, 9));
                    rq.load_fifties  = 16'($urandom_range(0, 9));
                    rq.load_hundreds = '0;
                end
            endcase
        end else if (pick < 20) begin
            rq.amount = '0;
        end else if (pick < 65) begin
            top = int'(funds / 10);
            if (top > 40 && $urandom_range(0, 1)) top = 40;
            rq.amount = 24'(10 * $urandom_range(0, top));
        end else if (pick < 72) begin
            rq.amount = funds[23:0];
        end else if (pick < 78) begin
            rq.amount = 24'(funds + 10 * $urandom_range(1, 5));
        end else if (pick < 88) begin
            rq.amount = 24'(10 * $urandom_range(0, 50) + $urandom_range(1, 9));
        end
        return rq;
    endfunction

    // Present one item and hold it until the block takes it.
    task automatic offer(input t_request rq);
        int gap;
        gap = pause_len();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_valid <= 1'b1;
        s_user  <= rq.cmd;
        s_data  <= {rq.load_hundreds, rq.load_fifties, rq.load_twenties, rq.load_tens,
                    rq.amount};
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        items_sent++;
    endtask

    task automatic compare_field(input string name, input logic [23:0] want, got);
        if (want !== got) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
                $display("result %0d: %s expected %0d, got %0d", receipts_seen, name, want, got);
        end
    endtask

    // Result side: random stalls, compare each accepted item against the oldest receipt.
    always @(posedge i_clk) begin
        t_receipt want;
        if (!i_rst_n) begin
            m_ready   <= 1'b0;
            recv_wait = 0;
        end else if (m_ready && o_m_axis_tvalid) begin
            receipts_seen++;
            if (pending_receipts.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("result %0d arrived with nothing expected", receipts_seen);
            end else begin
                want = pending_receipts.pop_front();
                tally[want.status]++;
                compare_field("status",        want.status,        o_m_axis_tuser);
                compare_field("paid_tens",     want.paid_tens,     o_m_axis_tdata[15:0]);
                compare_field("paid_twenties", want.paid_twenties, o_m_axis_tdata[31:16]);
                compare_field("paid_fifties",  want.paid_fifties,  o_m_axis_tdata[47:32]);
                compare_field("paid_hundreds", want.paid_hundreds, o_m_axis_tdata[63:48]);
                compare_field("left_tens",     want.left_tens,     o_m_axis_tdata[79:64]);
                compare_field("left_twenties", want.left_twenties, o_m_axis_tdata[95:80]);
                compare_field("left_fifties",  want.left_fifties,  o_m_axis_tdata[111:96]);
                compare_field("left_hundreds", want.left_hundreds, o_m_axis_tdata[127:112]);
                compare_field("balance",       want.balance,       o_m_axis_tdata[151:128]);
            end
            recv_wait = pause_len();
            m_ready   <= (recv_wait == 0);
        end else if (!m_ready) begin
            if (recv_wait <= 1) begin
                m_ready <= 1'b1;
            end else begin
                recv_wait = recv_wait - 1;
            end
        end
    end

    // Abort when neither side moves an item for too long.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((s_valid && o_s_axis_tready) || (m_ready && o_m_axis_tvalid)) begin
                idle_cycles <= 0;
            end else if (idle_cycles >= STALL_LIMIT) begin
                $display("no item moved for %0d cycles", STALL_LIMIT);
                $display("*** FAILED ***");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    initial begin
        t_vector  row;
        t_request rq;
        t_receipt due;
        int       n;

        add_row(withdraw(24'd0), 1'b1, slip(gnd_pkg::ST_PAID, 64'd0, 64'd0, 24'd0));
        add_row(withdraw(24'd10), 1'b1, slip(gnd_pkg::ST_LOW, 64'd0, 64'd0, 24'd0));
        add_row(withdraw(24'hFFFFFF), 1'b1, slip(gnd_pkg::ST_LOW, 64'd0, 64'd0, 24'd0));
        add_row(stock_load(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 24'hFFFFFF), 1'b1,
                slip(gnd_pkg::ST_LOADED, 64'd0, {4{16'hFFFF}}, 24'd11796300));
        add_row(withdraw(24'hFFFFFF), 1'b1,
                slip(gnd_pkg::ST_LOW, 64'd0, {4{16'hFFFF}}, 24'd11796300));
        // Exactly the full stock drains every note kind.
        add_row(withdraw(24'd11796300), 1'b1,
                slip(gnd_pkg::ST_PAID, {4{16'hFFFF}}, 64'd0, 24'd0));
        add_row(withdraw(24'd5), 1'b1, slip(gnd_pkg::ST_LOW, 64'd0, 64'd0, 24'd0));
        add_row(stock_load(16'd0, 16'd3, 16'd0, 16'd1, 24'd0), 1'b0, '0);
        add_row(withdraw(24'd60), 1'b0, '0);
        add_row(withdraw(24'd100), 1'b0, '0);
        // Greedy takes the fifty and strands a ten although three twenties would do.
        add_row(stock_load(16'd0, 16'd3, 16'd1, 16'd0, 24'd0), 1'b0, '0);
        add_row(withdraw(24'd60), 1'b0, '0);
        add_row(withdraw(24'd15), 1'b0, '0);
        add_row(withdraw(24'd110), 1'b0, '0);
        add_row(withdraw(24'd0), 1'b0, '0);
        add_row(stock_load(16'hAAAA, 16'h5555, 16'h00FF, 16'hFF00, 24'h555555), 1'b0, '0);
        add_row(withdraw(24'hAAAAAA), 1'b0, '0);
        add_row(withdraw(24'h555555), 1'b0, '0);
        add_row(withdraw(24'd5592400), 1'b0, '0);
        add_row(stock_load(16'd3, 16'd0, 16'd0, 16'd0, 24'hAAAAAA), 1'b0, '0);
        add_row(withdraw(24'd30), 1'b0, '0);
        add_row(withdraw(24'd10), 1'b0, '0);

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (n = 0; n < directed_rows.size(); n++) begin
            row = directed_rows[n];
            offer(row.req);
            due = dispense(row.req);
            pending_receipts.push_back(row.golden ? row.slip : due);
        end

        for (n = 0; n < RANDOM_ITEMS; n++) begin
            // Switch between idling and back-to-back stretches now and then.
            if (n % 150 == 0) idle_on = ($urandom_range(0, 3) != 0);
            rq = random_request();
            offer(rq);
            pending_receipts.push_back(dispense(rq));
        end
        s_valid <= 1'b0;

        while (pending_receipts.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Sent %0d items (%0d directed), checked %0d results, %0d mismatches",
                 items_sent, directed_rows.size(), receipts_seen, mismatches);
        $display("Outcomes: %0d paid, %0d balance short, %0d no note mix, %0d loads",
                 tally[gnd_pkg::ST_PAID], tally[gnd_pkg::ST_LOW],
                 tally[gnd_pkg::ST_NOCOMB], tally[gnd_pkg::ST_LOADED]);
        if (mismatches == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

/* files.f */
+incdir+src
src/gnd_pkg.sv
src/gnd_ctrl.sv
src/gnd_dpath.sv
src/greedy_note_dispenser.sv
bench/tb_greedy_note_dispenser.sv
